// File: sv/well512a_random_generator_core_macros.svh
// ----------------------------------------------------------------------------
// WELL512a generator assertion macros
// Shared concurrent assertion forms used by the core.
// ----------------------------------------------------------------------------
`ifndef WELL512A_RANDOM_GENERATOR_CORE_MACROS_SVH
`define WELL512A_RANDOM_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define WRG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/wrg_pkg.sv
// ----------------------------------------------------------------------------
// WELL512a generator package
// Shared types, codes and constants for controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrg_pkg;

    localparam int WORDS      = 16;
    localparam int WORD_W     = 32;
    localparam int SEED_W     = 64;
    localparam int SEED_STEPS = WORDS / 2;
    localparam int DIV_BITS   = WORD_W;
    localparam int CNT_W      = $clog2(DIV_BITS);

    localparam logic [1:0] ACT_RESEED = 2'd0;
    localparam logic [1:0] ACT_RAW    = 2'd1;
    localparam logic [1:0] ACT_RANGED = 2'd2;

    localparam logic [WORD_W-1:0] LCG_MUL     = 32'h5DEECE66;
    localparam logic [SEED_W-1:0] LCG_INC     = 64'hB;
    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hda442d24;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_PUSH,
        S_WELL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic seed_init;
        logic mul_lo;
        logic mul_hi;
        logic seed_push;
        logic well_step;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic raw;
        logic span_zero;
        logic out_free;
    } t_dp_status;

endpackage

// File: sv/wrg_ctrl.sv
// ----------------------------------------------------------------------------
// WELL512a generator controller
// Sequences reseed fill, state update, remainder divider and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrg_ctrl
    import wrg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall,
    output logic       o_cfg_ready
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_item = 1'b1;
                    n_cnt           = '0;
                    if (i_action == ACT_RESEED) begin
                        o_cmd.seed_init = 1'b1;
                        n_state         = S_MUL_LO;
                    end else if (i_action == ACT_RAW || i_action == ACT_RANGED) begin
                        n_state = S_WELL;
                    end
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.seed_push = 1'b1;
                if (r_cnt == CNT_W'(SEED_STEPS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_MUL_LO;
                end
            end
            S_WELL: begin
                o_cmd.well_step = 1'b1;
                n_cnt           = '0;
                if (i_status.raw || i_status.span_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/wrg_datapath.sv
// ----------------------------------------------------------------------------
// WELL512a generator datapath
// Rotating state window, seed LCG, restoring divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrg_datapath
    import wrg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic                     i_cfg_we,
    input  logic [SEED_W-1:0]        i_cfg_seed_value,
    input  logic [1:0]               i_action,
    input  logic signed [WORD_W-1:0] i_range_min,
    input  logic signed [WORD_W-1:0] i_range_max,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [WORD_W-1:0]        o_value
);

    // window slot k holds state word (ring index + k) mod 16
    logic [WORD_W-1:0] r_win [WORDS];
    logic [WORD_W-1:0] n_win [WORDS];

    logic [SEED_W-1:0] r_seed_value;
    logic [SEED_W-1:0] r_seed;
    logic [SEED_W-1:0] r_plo;
    logic [WORD_W-1:0] r_phi;
    logic [1:0]        r_action;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W-1:0] r_span;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvd;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_value;

    logic [WORD_W-1:0] w_z1, w_z2, w_n1, w_z4, w_n0;
    logic [WORD_W-1:0] w_w0, w_wm1, w_wm2, w_wq;
    logic [WORD_W:0]   w_rem_sh, w_rem_diff;
    logic [WORD_W-1:0] w_result;
    logic [WORD_W-1:0] w_mul_a;
    logic [SEED_W-1:0] w_mul_p;

    assign w_w0  = r_win[0];
    assign w_wm1 = r_win[13];
    assign w_wm2 = r_win[9];
    assign w_wq  = r_win[WORDS-1];

    assign w_z1 = (w_w0 ^ (w_w0 << 16)) ^ (w_wm1 ^ (w_wm1 << 15));
    assign w_z2 = w_wm2 ^ (w_wm2 >> 11);
    assign w_n1 = w_z1 ^ w_z2;
    assign w_z4 = w_n1 ^ ((w_n1 << 5) & TEMPER_MASK);
    assign w_n0 = (w_wq ^ (w_wq << 2)) ^ (w_z1 ^ (w_z1 << 18)) ^ (w_z2 << 28) ^ w_z4;

    // one 32x32 multiplier shared by both halves of the LCG step
    assign w_mul_a = i_cmd.mul_hi ? r_seed[SEED_W-1:WORD_W] : r_seed[WORD_W-1:0];
    assign w_mul_p = SEED_W'(w_mul_a) * SEED_W'(LCG_MUL);

    assign w_rem_sh   = {r_rem, r_dvd[WORD_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_span};

    assign w_result = (r_action == ACT_RAW) ? r_word :
                      (r_span == '0)        ? r_lo + r_word : r_lo + r_rem;

    assign o_status.raw       = (r_action == ACT_RAW);
    assign o_status.span_zero = (r_span == '0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

    always_comb begin
        for (int k = 0; k < WORDS; k++) begin
            n_win[k] = r_win[k];
        end
        if (i_cmd.seed_push) begin
            for (int k = 0; k < WORDS - 2; k++) begin
                n_win[k] = r_win[k+2];
            end
            n_win[WORDS-2] = r_seed[WORD_W-1:0];
            n_win[WORDS-1] = r_seed[SEED_W-1:WORD_W];
        end else if (i_cmd.well_step) begin
            n_win[0] = w_n0;
            n_win[1] = w_n1;
            for (int k = 2; k < WORDS; k++) begin
                n_win[k] = r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WORDS; k++) begin
                r_win[k] <= '0;
            end
            r_seed_value <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            for (int k = 0; k < WORDS; k++) begin
                r_win[k] <= n_win[k];
            end
            if (i_cfg_we) begin
                r_seed_value <= i_cfg_seed_value;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_lo     <= $unsigned(i_range_min);
            r_span   <= $unsigned(i_range_max) - $unsigned(i_range_min) + WORD_W'(1);
        end
        if (i_cmd.seed_init) begin
            r_seed <= r_seed_value;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= w_mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= w_mul_p[WORD_W-1:0];
        end
        if (i_cmd.seed_push) begin
            r_seed <= {r_plo[SEED_W-1:WORD_W] + r_phi, r_plo[WORD_W-1:0]} + LCG_INC;
        end
        if (i_cmd.well_step) begin
            r_word <= w_n0;
            r_dvd  <= w_n0;
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            r_rem <= w_rem_diff[WORD_W] ? w_rem_sh[WORD_W-1:0] : w_rem_diff[WORD_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_value <= w_result;
        end
    end

endmodule

// File: sv/well512a_random_generator_core.sv
// ----------------------------------------------------------------------------
// WELL512a random generator core
// Reseed, raw draw and ranged draw over a 512-bit WELL state.
// ----------------------------------------------------------------------------
// A reseed beat fills the state from the seed register (accept, then eight
// LCG steps in states MUL_LO, MUL_HI, PUSH on one shared 32x32 multiplier)
// and returns nothing. A raw draw captures the beat, updates the state and
// loads the output register once the sink no longer holds a stalled result.
// A ranged draw with a nonzero span adds the one-bit-per-cycle restoring
// remainder unit between the state update and the result load. A beat
// with action code 3 is taken and dropped. Input is stalled while an item
// is in progress; a finished result waits in the output register, and the
// next beat can be taken meanwhile. The seed register is written through
// the configuration channel, ready when idle.
`timescale 1ns / 1ps

module well512a_random_generator_core
    import wrg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [SEED_W-1:0]        i_cfg_seed_value,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_action,
    input  logic signed [WORD_W-1:0] i_range_min,
    input  logic signed [WORD_W-1:0] i_range_max,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [WORD_W-1:0]        o_value
);

`include "well512a_random_generator_core_macros.svh"

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_cfg_we;

    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    wrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    wrg_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_seed_value (i_cfg_seed_value),
        .i_action         (i_action),
        .i_range_min      (i_range_min),
        .i_range_max      (i_range_max),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_value          (o_value)
    );

    // result never overwrites a beat still held by the sink
    `WRG_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !(o_out_valid && i_out_stall), "result load over a stalled beat")
    // accepted draw keeps the input stalled while it runs
    `WRG_ASSERT_NEXT(a_draw_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_action == ACT_RAW || i_action == ACT_RANGED), o_in_stall && !o_cfg_ready, "draw accepted without going busy")
    // seed fill and state update never share a cycle
    `WRG_ASSERT_NOW(a_win_excl, i_clk, i_rst_n, w_cmd.seed_push, !w_cmd.well_step && !w_cmd.div_step, "window written by two sources")

endmodule
